// File: hw/rtl/ptw_pkg.sv
// ============================================================================
// ptw_pkg
// Shared types and constants of the two-level page table engine.
// ============================================================================
package ptw_pkg;

    // Command kinds carried by one input word.
    typedef enum logic [1:0] {
        KIND_MAP       = 2'd0,
        KIND_UNMAP     = 2'd1,
        KIND_TRANSLATE = 2'd2,
        KIND_REVERSE   = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DCHK,
        S_TRD,
        S_RDCHK,
        S_RTAB
    } t_state;

    // Address split and entry layout.
    localparam int DIR_SHIFT   = 22;
    localparam int TAB_SHIFT   = 12;
    localparam int IDX_W       = 10;
    localparam int FLAG_W      = 8;
    localparam int FRAME_LSB   = 10;
    localparam int PRESENT_BIT = 0;

endpackage

// File: hw/rtl/ptw_ram.sv
// ============================================================================
// ptw_ram
// Generic single-port synchronous RAM with a registered read port.
// ============================================================================
module ptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on request; the read word is registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/two_level_page_table_engine_core.sv
// ============================================================================
// two_level_page_table_engine_core
// Page directory and page table pool held in two RAMs, walked by one
// controller that reads, checks and writes back one command at a time.
// ============================================================================
// An out-of-range map, unmap or translate answers from the idle state; map
// and unmap answer after the directory read, translate after a further table
// read if its directory entry is present. Reverse lookup checks each entry
// in turn and scans the table of each present one (single table port).
// One command at a time; busy is low again as the strobe shows. The receiver
// cannot stall. Reset first clears both RAMs in a clearing pass, busy high.
module two_level_page_table_engine_core #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_SLOTS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [7:0]  i_page_flags,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_word
);

    localparam int FW    = ptw_pkg::FLAG_W;
    localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DIRW  = FW + SW;
    localparam int DW    = $clog2(DIR_ENTRIES);
    localparam int TIW   = $clog2(TABLE_ENTRIES);
    localparam int QW    = $clog2(TABLE_ENTRIES + 1);
    localparam int TDEP  = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int TAW   = $clog2(TDEP);
    localparam int NFW   = $clog2(TABLE_SLOTS + 1);
    localparam int CLR_N = (DIR_ENTRIES > TDEP) ? DIR_ENTRIES : TDEP;
    localparam int CW    = $clog2(CLR_N);
    localparam int IW    = ptw_pkg::IDX_W;
    localparam int FL    = ptw_pkg::FRAME_LSB;

    // Position of an entry inside the table pool.
    function automatic logic [TAW-1:0] tab_pos(input logic [SW-1:0] slot,
                                               input logic [IW-1:0] ti);
        tab_pos = TAW'(slot) * TAW'(TABLE_ENTRIES) + TAW'(ti);
    endfunction

    // Registers.
    ptw_pkg::t_state r_state, n_state;
    ptw_pkg::t_kind  r_kind, n_kind;
    logic [31:0]     r_virt, n_virt;
    logic [31:0]     r_phys, n_phys;
    logic [FW-1:0]   r_flags, n_flags;
    logic [DW-1:0]   r_di, n_di;
    logic [SW-1:0]   r_slot, n_slot;
    logic [QW-1:0]   r_qi, n_qi;
    logic            r_chk, n_chk;
    logic [TIW-1:0]  r_qc, n_qc;
    logic [NFW-1:0]  r_nfs, n_nfs;
    logic [CW-1:0]   r_clr, n_clr;
    logic            r_done, n_done;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_word, n_word;

    // Memory ports.
    logic            dir_we;
    logic [DW-1:0]   dir_ptr;
    logic [DIRW-1:0] dir_wdata;
    logic [DIRW-1:0] dir_rdata;
    logic            tab_we;
    logic [TAW-1:0]  tab_addr;
    logic [31:0]     tab_wdata;
    logic [31:0]     tab_rdata;

    // Decoded fields.
    logic [IW-1:0]   in_di;
    logic [IW-1:0]   in_ti;
    logic            in_range;
    logic [IW-1:0]   cur_ti;
    logic            d_present;
    logic [SW-1:0]   d_slot;
    logic [SW-1:0]   map_slot;
    logic            scan_hit;
    logic            dir_last;

    assign in_di     = i_virt_addr[31:ptw_pkg::DIR_SHIFT];
    assign in_ti     = i_virt_addr[ptw_pkg::DIR_SHIFT-1:ptw_pkg::TAB_SHIFT];
    assign in_range  = (32'(in_di) < DIR_ENTRIES) && (32'(in_ti) < TABLE_ENTRIES);
    assign cur_ti    = r_virt[ptw_pkg::DIR_SHIFT-1:ptw_pkg::TAB_SHIFT];
    assign d_present = dir_rdata[ptw_pkg::PRESENT_BIT];
    assign d_slot    = dir_rdata[FW +: SW];
    assign map_slot  = d_present ? d_slot : r_nfs[SW-1:0];
    assign dir_last  = (r_di == DW'(DIR_ENTRIES - 1));
    assign scan_hit  = r_chk && (tab_rdata[31:FL] != '0)
                     && (tab_rdata[31:FL] == r_phys[31:FL]);

    ptw_ram #(
        .WIDTH(DIRW),
        .DEPTH(DIR_ENTRIES)
    ) u_dir_ram (
        .i_clk  (i_clk),
        .i_we   (dir_we),
        .i_addr (dir_ptr),
        .i_wdata(dir_wdata),
        .o_rdata(dir_rdata)
    );

    ptw_ram #(
        .WIDTH(32),
        .DEPTH(TDEP)
    ) u_tab_ram (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_addr (tab_addr),
        .i_wdata(tab_wdata),
        .o_rdata(tab_rdata)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptw_pkg::S_CLEAR;
            r_clr   <= '0;
            r_nfs   <= '0;
            r_done  <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_nfs   <= n_nfs;
            r_done  <= n_done;
            r_chk   <= n_chk;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_virt   <= n_virt;
        r_phys   <= n_phys;
        r_flags  <= n_flags;
        r_di     <= n_di;
        r_slot   <= n_slot;
        r_qi     <= n_qi;
        r_qc     <= n_qc;
        r_status <= n_status;
        r_word   <= n_word;
    end

    // Next state, memory requests and result words.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_virt    = r_virt;
        n_phys    = r_phys;
        n_flags   = r_flags;
        n_di      = r_di;
        n_slot    = r_slot;
        n_qi      = r_qi;
        n_chk     = r_chk;
        n_qc      = r_qc;
        n_nfs     = r_nfs;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_status  = r_status;
        n_word    = r_word;
        dir_we    = 1'b0;
        dir_ptr   = r_di;
        dir_wdata = '0;
        tab_we    = 1'b0;
        tab_addr  = tab_pos(r_slot, cur_ti);
        tab_wdata = '0;

        unique case (r_state)
            // Zero both memories after reset.
            ptw_pkg::S_CLEAR: begin
                dir_we   = (32'(r_clr) < DIR_ENTRIES);
                dir_ptr  = r_clr[DW-1:0];
                tab_we   = (32'(r_clr) < TDEP);
                tab_addr = r_clr[TAW-1:0];
                n_clr    = r_clr + 1'b1;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = ptw_pkg::S_IDLE;
                end
            end

            // Take a command word and start its directory read.
            ptw_pkg::S_IDLE: begin
                dir_ptr = in_di[DW-1:0];
                if (start) begin
                    n_kind  = ptw_pkg::t_kind'(i_kind);
                    n_virt  = i_virt_addr;
                    n_phys  = i_phys_addr;
                    n_flags = i_page_flags;
                    if (ptw_pkg::t_kind'(i_kind) == ptw_pkg::KIND_REVERSE) begin
                        dir_ptr = '0;
                        n_di    = '0;
                        n_state = ptw_pkg::S_RDCHK;
                    end else if (in_range) begin
                        n_state = ptw_pkg::S_DCHK;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ptw_pkg::ST_MISS;
                        n_word   = '0;
                    end
                end
            end

            // Directory entry is here: map, unmap or start the table read.
            ptw_pkg::S_DCHK: begin
                dir_ptr  = r_virt[ptw_pkg::DIR_SHIFT +: DW];
                tab_addr = tab_pos(map_slot, cur_ti);
                n_word   = '0;
                n_status = ptw_pkg::ST_MISS;
                n_state  = ptw_pkg::S_IDLE;
                n_done   = 1'b1;
                case (r_kind)
                    ptw_pkg::KIND_MAP: begin
                        if (!d_present && (32'(r_nfs) >= TABLE_SLOTS)) begin
                            n_status = ptw_pkg::ST_FULL;
                        end else begin
                            if (!d_present) begin
                                n_nfs = r_nfs + 1'b1;
                            end
                            tab_we    = 1'b1;
                            tab_wdata = r_phys | 32'(r_flags) | 32'd1;
                            dir_we    = 1'b1;
                            dir_wdata = {map_slot, r_flags | FW'(1)};
                            n_status  = ptw_pkg::ST_OK;
                        end
                    end
                    ptw_pkg::KIND_UNMAP: begin
                        if (d_present) begin
                            tab_we   = 1'b1;
                            n_status = ptw_pkg::ST_OK;
                        end
                    end
                    ptw_pkg::KIND_TRANSLATE: begin
                        if (d_present) begin
                            n_done  = 1'b0;
                            n_state = ptw_pkg::S_TRD;
                        end
                    end
                    default: begin
                        n_status = ptw_pkg::ST_MISS;
                    end
                endcase
            end

            // Table entry for translate is here.
            ptw_pkg::S_TRD: begin
                n_done   = 1'b1;
                n_status = ptw_pkg::ST_OK;
                n_word   = tab_rdata;
                n_state  = ptw_pkg::S_IDLE;
            end

            // Reverse lookup: check one directory entry.
            ptw_pkg::S_RDCHK: begin
                if (d_present) begin
                    n_slot  = d_slot;
                    n_qi    = '0;
                    n_chk   = 1'b0;
                    n_state = ptw_pkg::S_RTAB;
                end else if (dir_last) begin
                    n_done   = 1'b1;
                    n_status = ptw_pkg::ST_MISS;
                    n_word   = '0;
                    n_state  = ptw_pkg::S_IDLE;
                end else begin
                    n_di    = r_di + 1'b1;
                    dir_ptr = r_di + 1'b1;
                end
            end

            // Reverse lookup: stream the table, one read issued per cycle.
            ptw_pkg::S_RTAB: begin
                tab_addr = tab_pos(r_slot, IW'(r_qi[TIW-1:0]));
                if (scan_hit) begin
                    n_done   = 1'b1;
                    n_status = ptw_pkg::ST_OK;
                    n_word   = {IW'(r_di), IW'(r_qc), 12'b0};
                    n_chk    = 1'b0;
                    n_state  = ptw_pkg::S_IDLE;
                end else if (r_qi == QW'(TABLE_ENTRIES)) begin
                    n_chk = 1'b0;
                    if (dir_last) begin
                        n_done   = 1'b1;
                        n_status = ptw_pkg::ST_MISS;
                        n_word   = '0;
                        n_state  = ptw_pkg::S_IDLE;
                    end else begin
                        n_di    = r_di + 1'b1;
                        dir_ptr = r_di + 1'b1;
                        n_state = ptw_pkg::S_RDCHK;
                    end
                end else begin
                    n_qc  = r_qi[TIW-1:0];
                    n_qi  = r_qi + 1'b1;
                    n_chk = 1'b1;
                end
            end

            default: begin
                n_state = ptw_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != ptw_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_result_word = r_word;

endmodule
